### hw/rtl/ckf_pkg.sv
// Shared types, codes and helper functions for the connection keepalive state machine.
package ckf_pkg;

    localparam int AGE_BITS             = 20;
    localparam int CFG_BITS             = 20;
    localparam int CFG_IDX_BITS         = 2;
    localparam int KEEPALIVE_TIMEOUT_MS = 3000;
    localparam int REASON_BITS          = 8;
    localparam int REQ_BITS             = 4;
    localparam int STATE_BITS           = 3;
    localparam int KIND_BITS            = 3;
    localparam int IN_DATA_BITS         = 16;
    localparam int IN_USER_BITS         = 4;
    localparam int OUT_DATA_BITS        = 24;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] CFG_KEEPALIVE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINGER             = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CONNECT        = 2'd2;

    localparam logic [CFG_BITS-1:0] LINGER_RESET      = CFG_BITS'(1000);
    localparam logic [CFG_BITS-1:0] MAX_CONNECT_RESET = CFG_BITS'(5000);

    typedef enum logic [REQ_BITS-1:0] {
        REQ_TICK           = 4'd0,
        REQ_DISCONNECT     = 4'd1,
        REQ_ACCEPT_DISC    = 4'd2,
        REQ_BAD_PW         = 4'd3,
        REQ_CONN_REQ       = 4'd4,
        REQ_CONN_ACCEPT    = 4'd5,
        REQ_KA_REQ         = 4'd6,
        REQ_KA_ANS         = 4'd7,
        REQ_SEND_BAD_PW    = 4'd8,
        REQ_RX_ACCEPT      = 4'd9,
        REQ_RX_KA_ANS      = 4'd10,
        REQ_RX_REMOTE_DISC = 4'd11
    } t_req;

    typedef enum logic [KIND_BITS-1:0] {
        PK_DISCONNECT   = 3'd0,
        PK_CONN_REQ     = 3'd1,
        PK_CONN_ACCEPT  = 3'd2,
        PK_KA_REQ       = 3'd3,
        PK_KA_ANS       = 3'd4,
        PK_BAD_PW       = 3'd5
    } t_kind;

    typedef enum logic [7:0] {
        ST_IDLE          = 8'b0000_0001,
        ST_CONNECTING    = 8'b0000_0010,
        ST_CONNECTED     = 8'b0000_0100,
        ST_DISCONNECTING = 8'b0000_1000,
        ST_DISCONNECTED  = 8'b0001_0000,
        ST_INVALID_PW    = 8'b0010_0000,
        ST_INIT_TIMEOUT  = 8'b0100_0000,
        ST_CONN_TIMEOUT  = 8'b1000_0000
    } t_conn_state;

    typedef struct packed {
        logic                   awaiting_keepalive;
        logic [REASON_BITS-1:0] reason_out;
        logic [STATE_BITS-1:0]  conn_state_out;
        logic [KIND_BITS-1:0]   send_kind;
        logic                   send_valid;
        logic                   accepted;
    } t_result;

    function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] age);
        age_inc = (age == AGE_MAX) ? AGE_MAX : age + AGE_BITS'(1);
    endfunction

    function automatic logic [STATE_BITS-1:0] state_code(input t_conn_state st);
        logic [STATE_BITS-1:0] code;
        case (st)
            ST_IDLE:          code = 3'd0;
            ST_CONNECTING:    code = 3'd1;
            ST_CONNECTED:     code = 3'd2;
            ST_DISCONNECTING: code = 3'd3;
            ST_DISCONNECTED:  code = 3'd4;
            ST_INVALID_PW:    code = 3'd5;
            ST_INIT_TIMEOUT:  code = 3'd6;
            ST_CONN_TIMEOUT:  code = 3'd7;
            default:          code = 3'd0;
        endcase
        state_code = code;
    endfunction

endpackage

### hw/rtl/connection_keepalive_fsm_unit.sv
// Top level of the connection keepalive state machine with its stream ports.
// A request is taken into the input register, and its result is then written to the result register.
// Throughput: one request per cycle while the output is taken; the input register feeds the
// state update logic, which writes the result register and the state in the same cycle.
// Reset (synchronous, active low): state idle, ages zero except the answer age,
// which starts saturated; registers return to their reset values; both stages empty.
module connection_keepalive_fsm_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: endpoint_ok, remote_is_self, reason_in, zero fill.
    input  logic [ckf_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
    // Fields from bit 0: req_type.
    input  logic [ckf_pkg::IN_USER_BITS-1:0] s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: accepted, send_valid, send_kind, conn_state_out,
    // reason_out, awaiting_keepalive, zero fill.
    output logic [ckf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [ckf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ckf_pkg::CFG_BITS-1:0]     i_cfg_wdata
);
    import ckf_pkg::*;

    logic [CFG_BITS-1:0]    r_ka_interval;
    logic [CFG_BITS-1:0]    r_linger;
    logic [CFG_BITS-1:0]    r_max_connect;

    logic                   r_in_valid;
    logic [REQ_BITS-1:0]    r_in_req;
    logic                   r_in_ep_ok;
    logic                   r_in_is_self;
    logic [REASON_BITS-1:0] r_in_reason;

    t_conn_state            r_state, n_state;
    logic                   r_waiting, n_waiting;
    logic [AGE_BITS-1:0]    r_connect_age, n_connect_age;
    logic [AGE_BITS-1:0]    r_request_age, n_request_age;
    logic [AGE_BITS-1:0]    r_answer_age, n_answer_age;
    logic [AGE_BITS-1:0]    r_disconnect_age, n_disconnect_age;

    logic                   r_out_valid;
    t_result                r_out, n_out;

    logic                   adv;
    logic                   fire;
    logic                   ka_enabled;
    logic                   acc;
    logic                   snd;
    t_kind                  pk;
    logic [REASON_BITS-1:0] rsn;

    assign adv           = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && adv;
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_BITS - $bits(t_result))'(0), r_out};
    assign ka_enabled    = (r_ka_interval != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka_interval <= '0;
            r_linger      <= LINGER_RESET;
            r_max_connect <= MAX_CONNECT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEEPALIVE_INTERVAL: r_ka_interval <= i_cfg_wdata;
                CFG_LINGER:             r_linger      <= i_cfg_wdata;
                CFG_MAX_CONNECT:        r_max_connect <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req     <= s_axis_tuser[REQ_BITS-1:0];
            r_in_ep_ok   <= s_axis_tdata[0];
            r_in_is_self <= s_axis_tdata[1];
            r_in_reason  <= s_axis_tdata[2 +: REASON_BITS];
        end
    end

    always_comb begin
        n_state          = r_state;
        n_waiting        = r_waiting;
        n_connect_age    = r_connect_age;
        n_request_age    = r_request_age;
        n_answer_age     = r_answer_age;
        n_disconnect_age = r_disconnect_age;
        acc              = 1'b0;
        snd              = 1'b0;
        pk               = PK_DISCONNECT;
        rsn              = '0;
        case (r_in_req)
            REQ_TICK: begin
                acc              = 1'b1;
                n_connect_age    = age_inc(r_connect_age);
                n_request_age    = age_inc(r_request_age);
                n_answer_age     = age_inc(r_answer_age);
                n_disconnect_age = age_inc(r_disconnect_age);
                if (r_state == ST_CONNECTING) begin
                    if (n_connect_age >= AGE_BITS'(r_max_connect)) begin
                        n_state = ST_INIT_TIMEOUT;
                    end
                end else if (r_state == ST_CONNECTED) begin
                    if (ka_enabled) begin
                        if (!r_waiting) begin
                            if (n_answer_age > AGE_BITS'(r_ka_interval)) begin
                                n_request_age = '0;
                                n_waiting     = 1'b1;
                                snd           = 1'b1;
                                pk            = PK_KA_REQ;
                            end
                        end else if (n_request_age > AGE_BITS'(KEEPALIVE_TIMEOUT_MS)) begin
                            n_state = ST_CONN_TIMEOUT;
                        end
                    end
                end else if (r_state == ST_DISCONNECTING) begin
                    if (n_disconnect_age > AGE_BITS'(r_linger)) begin
                        n_state = ST_DISCONNECTED;
                    end
                end
            end
            REQ_DISCONNECT: begin
                if (r_state == ST_CONNECTED) begin
                    acc              = 1'b1;
                    n_state          = ST_DISCONNECTING;
                    n_disconnect_age = '0;
                    snd              = 1'b1;
                    pk               = PK_DISCONNECT;
                end
            end
            REQ_ACCEPT_DISC: begin
                if (r_state == ST_CONNECTED) begin
                    acc     = 1'b1;
                    n_state = ST_DISCONNECTED;
                end
            end
            REQ_BAD_PW: begin
                if (r_state == ST_CONNECTING) begin
                    acc     = 1'b1;
                    n_state = ST_INVALID_PW;
                end
            end
            REQ_CONN_REQ: begin
                if (r_state == ST_IDLE) begin
                    acc           = 1'b1;
                    n_state       = ST_CONNECTING;
                    n_connect_age = '0;
                    snd           = 1'b1;
                    pk            = PK_CONN_REQ;
                end
            end
            REQ_CONN_ACCEPT: begin
                if (r_state == ST_IDLE) begin
                    acc     = 1'b1;
                    n_state = ST_CONNECTED;
                    snd     = 1'b1;
                    pk      = PK_CONN_ACCEPT;
                end
            end
            REQ_KA_REQ: begin
                if (ka_enabled && r_state == ST_CONNECTED) begin
                    acc           = 1'b1;
                    n_request_age = '0;
                    n_waiting     = 1'b1;
                    snd           = 1'b1;
                    pk            = PK_KA_REQ;
                end
            end
            REQ_KA_ANS: begin
                if (r_state == ST_CONNECTED) begin
                    acc = 1'b1;
                    snd = 1'b1;
                    pk  = PK_KA_ANS;
                end
            end
            REQ_SEND_BAD_PW: begin
                if (r_state == ST_IDLE) begin
                    acc = 1'b1;
                    snd = 1'b1;
                    pk  = PK_BAD_PW;
                end
            end
            REQ_RX_ACCEPT: begin
                if (r_state == ST_CONNECTING) begin
                    acc           = 1'b1;
                    n_state       = ST_CONNECTED;
                    n_request_age = '0;
                end
            end
            REQ_RX_KA_ANS: begin
                acc          = 1'b1;
                n_waiting    = 1'b0;
                n_answer_age = '0;
            end
            REQ_RX_REMOTE_DISC: begin
                if (r_in_ep_ok && !(r_in_is_self && r_state != ST_CONNECTED)) begin
                    acc = 1'b1;
                    rsn = r_in_reason;
                end
            end
            default: ;
        endcase

        n_out.accepted           = acc;
        n_out.send_valid         = snd;
        n_out.send_kind          = pk;
        n_out.conn_state_out     = state_code(n_state);
        n_out.reason_out         = rsn;
        n_out.awaiting_keepalive = n_waiting;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_waiting        <= 1'b0;
            r_connect_age    <= '0;
            r_request_age    <= '0;
            r_answer_age     <= AGE_MAX;
            r_disconnect_age <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_state          <= n_state;
                r_waiting        <= n_waiting;
                r_connect_age    <= n_connect_age;
                r_request_age    <= n_request_age;
                r_answer_age     <= n_answer_age;
                r_disconnect_age <= n_disconnect_age;
            end
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // A processed request always shows up as a result in the next cycle.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed request did not produce a result");

    // A packet or a reason is only reported for an accepted request.
    a_send_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.accepted || (!r_out.send_valid && r_out.reason_out == '0)))
        else $error("packet or reason reported for a rejected request");

    // A received keepalive answer clears the flag and restarts the answer age.
    a_rx_answer_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_req == REQ_RX_KA_ANS) |=> (!r_waiting && r_answer_age == '0))
        else $error("keepalive answer did not clear the waiting state");

    // The state and the ages only change when a request is processed.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> ($stable(r_state) && $stable(r_waiting) && $stable(r_answer_age)))
        else $error("state changed without a processed request");

    // The reported state matches the state register after the update.
    a_state_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out.conn_state_out == state_code(r_state)))
        else $error("reported state differs from the state register");

endmodule

### dv/connection_keepalive_fsm_unit_test.sv
// Self-checking stream testbench for connection_keepalive_fsm_unit with a built-in predictor.
`timescale 1ns / 1ps

module connection_keepalive_fsm_unit_test;
    import ckf_pkg::*;

    typedef enum logic [STATE_BITS-1:0] {
        LS_IDLE,
        LS_CONNECTING,
        LS_CONNECTED,
        LS_DISCONNECTING,
        LS_DISCONNECTED,
        LS_INVALID_PW,
        LS_INIT_TIMEOUT,
        LS_CONN_TIMEOUT
    } t_link_state;

    typedef struct packed {
        logic [REQ_BITS-1:0]    code;
        logic                   ep_ok;
        logic                   is_self;
        logic [REASON_BITS-1:0] reason;
    } t_link_event;

    localparam logic [REQ_BITS-1:0]     REQ_UNUSED_LO  = 4'd12;
    localparam logic [REQ_BITS-1:0]     REQ_UNUSED_HI  = 4'd15;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int                      RESULT_BITS    = $bits(t_result);
    localparam int                      RX_HOLD_CYCLES = 64;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic [IN_USER_BITS-1:0]  s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_BITS-1:0]      i_cfg_wdata = '0;

    t_link_event pending_events[$];
    t_result     expected_results[$];
    t_link_event live_event;
    int unsigned events_queued = 0;
    int unsigned events_accepted = 0;
    int unsigned error_count = 0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned rx_hold_left = 0;
    bit          rx_hold_arm = 1'b0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    logic [CFG_BITS-1:0] ka_interval_ms = '0;
    logic [CFG_BITS-1:0] linger_ms = LINGER_RESET;
    logic [CFG_BITS-1:0] max_connect_ms = MAX_CONNECT_RESET;
    t_link_state         link_state = LS_IDLE;
    logic                ka_waiting = 1'b0;
    logic [AGE_BITS-1:0] connect_age = '0;
    logic [AGE_BITS-1:0] request_age = '0;
    logic [AGE_BITS-1:0] answer_age = AGE_MAX;
    logic [AGE_BITS-1:0] disconnect_age = '0;

    connection_keepalive_fsm_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [AGE_BITS-1:0] bump_age(input logic [AGE_BITS-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    function automatic t_result predict_event(input t_link_event ev);
        t_result r;
        r = '0;
        case (ev.code)
            REQ_TICK: begin
                r.accepted     = 1'b1;
                connect_age    = bump_age(connect_age);
                request_age    = bump_age(request_age);
                answer_age     = bump_age(answer_age);
                disconnect_age = bump_age(disconnect_age);
                case (link_state)
                    LS_CONNECTING: begin
                        if (connect_age >= max_connect_ms)
                            link_state = LS_INIT_TIMEOUT;
                    end
                    LS_CONNECTED: begin
                        if (ka_interval_ms != '0) begin
                            if (!ka_waiting) begin
                                if (answer_age > ka_interval_ms) begin
                                    request_age  = '0;
                                    ka_waiting   = 1'b1;
                                    r.send_valid = 1'b1;
                                    r.send_kind  = PK_KA_REQ;
                                end
                            end else if (request_age > AGE_BITS'(KEEPALIVE_TIMEOUT_MS)) begin
                                link_state = LS_CONN_TIMEOUT;
                            end
                        end
                    end
                    LS_DISCONNECTING: begin
                        if (disconnect_age > linger_ms)
                            link_state = LS_DISCONNECTED;
                    end
                    default: ;
                endcase
            end
            REQ_DISCONNECT: begin
                if (link_state == LS_CONNECTED) begin
                    r.accepted     = 1'b1;
                    link_state     = LS_DISCONNECTING;
                    disconnect_age = '0;
                    r.send_valid   = 1'b1;
                    r.send_kind    = PK_DISCONNECT;
                end
            end
            REQ_ACCEPT_DISC: begin
                if (link_state == LS_CONNECTED) begin
                    r.accepted = 1'b1;
                    link_state = LS_DISCONNECTED;
                end
            end
            REQ_BAD_PW: begin
                if (link_state == LS_CONNECTING) begin
                    r.accepted = 1'b1;
                    link_state = LS_INVALID_PW;
                end
            end
            REQ_CONN_REQ: begin
                if (link_state == LS_IDLE) begin
                    r.accepted   = 1'b1;
                    link_state   = LS_CONNECTING;
                    connect_age  = '0;
                    r.send_valid = 1'b1;
                    r.send_kind  = PK_CONN_REQ;
                end
            end
            REQ_CONN_ACCEPT: begin
                if (link_state == LS_IDLE) begin
                    r.accepted   = 1'b1;
                    link_state   = LS_CONNECTED;
                    r.send_valid = 1'b1;
                    r.send_kind  = PK_CONN_ACCEPT;
                end
            end
            REQ_KA_REQ: begin
                if (ka_interval_ms != '0 && link_state == LS_CONNECTED) begin
                    r.accepted   = 1'b1;
                    request_age  = '0;
                    ka_waiting   = 1'b1;
                    r.send_valid = 1'b1;
                    r.send_kind  = PK_KA_REQ;
                end
            end
            REQ_KA_ANS: begin
                if (link_state == LS_CONNECTED) begin
                    r.accepted   = 1'b1;
                    r.send_valid = 1'b1;
                    r.send_kind  = PK_KA_ANS;
                end
            end
            REQ_SEND_BAD_PW: begin
                if (link_state == LS_IDLE) begin
                    r.accepted   = 1'b1;
                    r.send_valid = 1'b1;
                    r.send_kind  = PK_BAD_PW;
                end
            end
            REQ_RX_ACCEPT: begin
                if (link_state == LS_CONNECTING) begin
                    r.accepted  = 1'b1;
                    link_state  = LS_CONNECTED;
                    request_age = '0;
                end
            end
            REQ_RX_KA_ANS: begin
                r.accepted = 1'b1;
                ka_waiting = 1'b0;
                answer_age = '0;
            end
            REQ_RX_REMOTE_DISC: begin
                if (ev.ep_ok && !(ev.is_self && link_state != LS_CONNECTED)) begin
                    r.accepted   = 1'b1;
                    r.reason_out = ev.reason;
                end
            end
            default: ;
        endcase
        r.conn_state_out     = link_state;
        r.awaiting_keepalive = ka_waiting;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input logic [OUT_DATA_BITS-1:0] word);
        t_result want;
        t_result got;
        if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result %h arrived with none expected, actual %h",
                     $time, word, word);
        end else begin
            want = expected_results.pop_front();
            got  = t_result'(word[RESULT_BITS-1:0]);
            compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
            compare_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
            compare_field("send_kind", 32'(want.send_kind), 32'(got.send_kind));
            compare_field("conn_state_out", 32'(want.conn_state_out),
                          32'(got.conn_state_out));
            compare_field("reason_out", 32'(want.reason_out), 32'(got.reason_out));
            compare_field("awaiting_keepalive", 32'(want.awaiting_keepalive),
                          32'(got.awaiting_keepalive));
            compare_field("zero fill", 0, 32'(word[OUT_DATA_BITS-1:RESULT_BITS]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_event(live_event));
                events_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait = tx_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    live_event = pending_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= live_event.code;
                    s_axis_tdata  <= IN_DATA_BITS'({live_event.reason, live_event.is_self,
                                                    live_event.ep_ok});
                    tx_wait = tx_idle_on ? $urandom_range(0, 9) : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            rx_hold_left <= 0;
        else if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
        else if (rx_hold_arm)
            rx_hold_left <= RX_HOLD_CYCLES;
    end

    task automatic queue_event(input logic [REQ_BITS-1:0] code, input logic ep,
                               input logic slf, input logic [REASON_BITS-1:0] rsn);
        t_link_event ev;
        ev.code    = code;
        ev.ep_ok   = ep;
        ev.is_self = slf;
        ev.reason  = rsn;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic queue_code(input logic [REQ_BITS-1:0] code);
        queue_event(code, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    REASON_BITS'($urandom_range(0, 255)));
    endtask

    task automatic queue_noise(input int unsigned count);
        repeat (count) queue_code(REQ_BITS'($urandom_range(0, 15)));
    endtask

    // Traffic that keeps the link up: disconnect requests are swapped for ticks.
    task automatic queue_connected_mix(input int unsigned count);
        int unsigned pick;
        logic [REQ_BITS-1:0] code;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                code = REQ_TICK;
            else if (pick < 60)
                code = REQ_RX_KA_ANS;
            else if (pick < 68)
                code = REQ_KA_REQ;
            else if (pick < 76)
                code = REQ_KA_ANS;
            else if (pick < 86)
                code = REQ_RX_REMOTE_DISC;
            else begin
                code = REQ_BITS'($urandom_range(0, 15));
                if (code == REQ_DISCONNECT || code == REQ_ACCEPT_DISC)
                    code = REQ_TICK;
            end
            queue_code(code);
        end
    endtask

    task automatic drain_all();
        while (events_accepted != events_queued || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_KEEPALIVE_INTERVAL: ka_interval_ms = value;
            CFG_LINGER:             linger_ms = value;
            CFG_MAX_CONNECT:        max_connect_ms = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_BITS-1:0] ka, input logic [CFG_BITS-1:0] lg,
                                input logic [CFG_BITS-1:0] mc);
        drain_all();
        write_reg(CFG_KEEPALIVE_INTERVAL, ka);
        write_reg(CFG_LINGER, lg);
        write_reg(CFG_MAX_CONNECT, mc);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    function automatic logic [CFG_BITS-1:0] pick_reg();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return CFG_BITS'(1000000);
            default: return CFG_BITS'($urandom_range(0, 1000000));
        endcase
    endfunction

    initial begin
        logic [CFG_BITS-1:0] ka_plan [6];
        logic [CFG_BITS-1:0] mc;
        logic [CFG_BITS-1:0] lg;
        int unsigned         route;
        int unsigned         ending;
        bit                  link_up;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle state: most request kinds, remote disconnect variants, unused codes.
        queue_event(REQ_TICK, 1'b0, 1'b0, 8'h00);
        queue_event(REQ_DISCONNECT, 1'b1, 1'b1, 8'hFF);
        queue_event(REQ_ACCEPT_DISC, 1'b0, 1'b0, 8'h00);
        queue_event(REQ_BAD_PW, 1'b1, 1'b0, 8'h5A);
        queue_event(REQ_KA_REQ, 1'b0, 1'b1, 8'hA5);
        queue_event(REQ_KA_ANS, 1'b1, 1'b1, 8'h01);
        queue_event(REQ_RX_ACCEPT, 1'b0, 1'b0, 8'h80);
        queue_event(REQ_SEND_BAD_PW, 1'b0, 1'b0, 8'h00);
        queue_event(REQ_RX_REMOTE_DISC, 1'b0, 1'b0, 8'hA5);
        queue_event(REQ_RX_REMOTE_DISC, 1'b1, 1'b1, 8'hFF);
        queue_event(REQ_RX_REMOTE_DISC, 1'b1, 1'b0, 8'hFF);
        queue_event(REQ_RX_REMOTE_DISC, 1'b1, 1'b0, 8'h00);
        queue_event(REQ_UNUSED_LO, 1'b1, 1'b1, 8'hFF);
        queue_event(REQ_UNUSED_HI, 1'b1, 1'b1, 8'hFF);
        queue_event(REQ_TICK, 1'b1, 1'b1, 8'hFF);
        drain_all();

        ka_plan[0] = CFG_BITS'($urandom_range(1, 8));
        ka_plan[1] = '0;
        ka_plan[2] = CFG_BITS'($urandom_range(2, 40));
        ka_plan[3] = '1;
        ka_plan[4] = CFG_BITS'(1000000);
        ka_plan[5] = CFG_BITS'(1);

        write_reg(CFG_UNUSED_IDX, CFG_BITS'($urandom_range(0, (1 << CFG_BITS) - 1)));
        route = $urandom_range(0, 19);
        if (route >= 14 && route < 17)
            mc = $urandom_range(0, 1) ? '0 : CFG_BITS'($urandom_range(1, 20));
        else
            mc = $urandom_range(0, 1) ? '1 : CFG_BITS'(1000000);
        program_regs(ka_plan[0], pick_reg(), mc);

        link_up = (route < 14);
        if (route < 7) begin
            queue_code(REQ_CONN_ACCEPT);
        end else if (route < 14) begin
            queue_code(REQ_CONN_REQ);
            repeat ($urandom_range(0, 12)) queue_code(REQ_TICK);
            queue_code(REQ_KA_REQ);
            queue_code(REQ_DISCONNECT);
            queue_code(REQ_RX_ACCEPT);
        end else if (route < 17) begin
            queue_code(REQ_CONN_REQ);
            repeat (mc + 3) queue_code(REQ_TICK);
        end else begin
            queue_code(REQ_CONN_REQ);
            queue_code(REQ_TICK);
            queue_code(REQ_BAD_PW);
        end

        if (link_up) begin
            foreach (ka_plan[i]) begin
                program_regs(ka_plan[i], pick_reg(), pick_reg());
                queue_connected_mix(250);
            end
            ending = $urandom_range(0, 2);
            if (ending == 0) begin
                // No answers at all, so the outstanding request times out.
                program_regs(CFG_BITS'(1), pick_reg(), pick_reg());
                repeat (KEEPALIVE_TIMEOUT_MS + 10) queue_code(REQ_TICK);
            end else if (ending == 1) begin
                lg = CFG_BITS'($urandom_range(0, 30));
                program_regs(CFG_BITS'($urandom_range(0, 20)), lg, pick_reg());
                queue_code(REQ_DISCONNECT);
                queue_noise(10);
                repeat (lg + 3) queue_code(REQ_TICK);
            end else begin
                queue_code(REQ_ACCEPT_DISC);
            end
        end

        // The receiver stalls while requests keep coming, so the input backs up.
        program_regs(pick_reg(), pick_reg(), pick_reg());
        tx_idle_on = 1'b0;
        rx_hold_arm = 1'b1;
        queue_noise(300);
        while (rx_hold_left == 0) @(posedge i_clk);
        rx_hold_arm = 1'b0;
        while (rx_hold_left != 0) @(posedge i_clk);
        tx_idle_on = 1'b1;

        drain_all();
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("connection_keepalive_fsm_unit verification clean");
        else
            $display("connection_keepalive_fsm_unit verification failed");
        $finish;
    end

    initial begin
        #7200000;
        $display("connection_keepalive_fsm_unit verification failed");
        $finish;
    end

endmodule
